/* rtl/backlight_fade_screensaver_core_defines.svh */
// ---------------------------------------------------------------------------
// Backlight fade screensaver - assertion macros
// Shared concurrent assertion forms for the RTL of the backlight controller.
// ---------------------------------------------------------------------------
`ifndef BACKLIGHT_FADE_SCREENSAVER_CORE_DEFINES_SVH
`define BACKLIGHT_FADE_SCREENSAVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFS_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bfs assertion failed");

// Next-cycle implication, disabled during reset.
`define BFS_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bfs assertion failed");

`endif

/* rtl/bfs_pkg.sv */
// ---------------------------------------------------------------------------
// bfs_pkg
// Types and constants shared by the backlight fade screensaver RTL.
// ---------------------------------------------------------------------------
package bfs_pkg;

  localparam int unsigned LEVEL_W       = 8;
  localparam int unsigned REQ_W         = 16;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned THRESH_W      = 26;  // 65535 * 1000 < 2^26
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL      = 8'd255;
  localparam logic [LEVEL_W-1:0] SAVER_SPEED    = 8'd2;
  localparam logic [LEVEL_W-1:0] RESET_STEP     = 8'd1;
  localparam logic [LEVEL_W-1:0] RESET_DEFAULT  = 8'd255;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    FN_STEP       = 3'd0,
    FN_SET_LEVEL  = 3'd1,
    FN_SET_SMOOTH = 3'd2,
    FN_ON         = 3'd3,
    FN_OFF        = 3'd4,
    FN_TOGGLE     = 3'd5,
    FN_TOUCH      = 3'd6,
    FN_INIT       = 3'd7
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEFAULT_BRIGHTNESS = 1'd0,
    CFG_IDLE_TIMEOUT       = 1'd1
  } cfg_addr_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  default_brightness;
    logic [THRESH_W-1:0] idle_thresh_ms;    // timeout in ms, 0 = saver off
  } cfg_t;

  typedef struct packed {
    func_t              func;
    logic [TIME_W-1:0]  now_ms;
    logic [REQ_W-1:0]   level;
    logic [LEVEL_W-1:0] speed;
  } item_t;

  typedef struct packed {
    logic               indicator_led;
    logic               was_off;
    logic               is_on;
    logic [LEVEL_W-1:0] pwm_level;
  } result_t;

endpackage

/* rtl/bfs_cfg.sv */
// ---------------------------------------------------------------------------
// bfs_cfg
// Configuration registers; the idle timeout is held pre-scaled to ms.
// ---------------------------------------------------------------------------
module bfs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bfs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bfs_pkg::cfg_t                     cfg
);

  logic [bfs_pkg::THRESH_W-1:0] thresh_next;

  // secs >= T is the same as elapsed_ms >= T * 1000
  assign thresh_next = {{(bfs_pkg::THRESH_W-bfs_pkg::TIMEOUT_W){1'b0}},
                        cfg_wdata[bfs_pkg::TIMEOUT_W-1:0]}
                       * bfs_pkg::THRESH_W'(bfs_pkg::MS_PER_SECOND);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_brightness <= bfs_pkg::RESET_DEFAULT;
      cfg.idle_thresh_ms     <= '0;
    end else if (cfg_we) begin
      unique case (bfs_pkg::cfg_addr_t'(cfg_addr))
        bfs_pkg::CFG_DEFAULT_BRIGHTNESS: begin
          cfg.default_brightness <= cfg_wdata[bfs_pkg::LEVEL_W-1:0];
        end
        bfs_pkg::CFG_IDLE_TIMEOUT: begin
          cfg.idle_thresh_ms <= thresh_next;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/bfs_engine.sv */
// ---------------------------------------------------------------------------
// bfs_engine
// Backlight state and the single-pass command / fade step logic.
// ---------------------------------------------------------------------------
`include "backlight_fade_screensaver_core_defines.svh"

module bfs_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,    // item in the input register is retired
  input  bfs_pkg::item_t      item,
  input  bfs_pkg::cfg_t       cfg,
  output bfs_pkg::result_t    result
);

  logic [bfs_pkg::LEVEL_W-1:0] level_now, level_now_next;
  logic [bfs_pkg::LEVEL_W-1:0] level_target, level_target_next;
  logic [bfs_pkg::LEVEL_W-1:0] fade_step, fade_step_next;
  logic [bfs_pkg::TIME_W-1:0]  last_touch_ms, last_touch_ms_next;
  logic                        indicator_flag, indicator_flag_next;

  logic [bfs_pkg::LEVEL_W-1:0] req_sat;
  logic [bfs_pkg::TIME_W-1:0]  elapsed;
  logic                        saver;
  logic [bfs_pkg::LEVEL_W-1:0] tgt_s, step_s;
  logic [bfs_pkg::LEVEL_W:0]   sum_up;
  logic [bfs_pkg::LEVEL_W-1:0] diff_dn, p_up, p_dn, p_step;
  logic                        was_off;

  assign req_sat = (|item.level[bfs_pkg::REQ_W-1:bfs_pkg::LEVEL_W]) ? bfs_pkg::MAX_LEVEL
                                                                     : item.level[bfs_pkg::LEVEL_W-1:0];

  // screensaver check
  assign elapsed = item.now_ms - last_touch_ms;
  assign saver   = (cfg.idle_thresh_ms != '0) && (level_now != '0) &&
                   (elapsed >= {{(bfs_pkg::TIME_W-bfs_pkg::THRESH_W){1'b0}},
                                cfg.idle_thresh_ms});
  assign tgt_s   = saver ? '0 : level_target;
  assign step_s  = saver ? bfs_pkg::SAVER_SPEED : fade_step;

  // fade step, clamped at the target
  assign sum_up  = {1'b0, level_now} + {1'b0, step_s};
  assign p_up    = (sum_up > {1'b0, tgt_s}) ? tgt_s : sum_up[bfs_pkg::LEVEL_W-1:0];
  assign diff_dn = level_now - tgt_s;
  assign p_dn    = (step_s >= diff_dn) ? tgt_s : level_now - step_s;
  assign p_step  = (level_now < tgt_s) ? p_up :
                   (level_now > tgt_s) ? p_dn : level_now;

  always_comb begin
    level_now_next      = level_now;
    level_target_next   = level_target;
    fade_step_next      = fade_step;
    last_touch_ms_next  = last_touch_ms;
    indicator_flag_next = indicator_flag;
    was_off             = 1'b0;
    case (item.func)
      bfs_pkg::FN_STEP: begin
        level_now_next      = p_step;
        level_target_next   = tgt_s;
        fade_step_next      = step_s;
        indicator_flag_next = indicator_flag | (p_step == '0);
      end
      bfs_pkg::FN_SET_LEVEL: begin
        level_now_next     = req_sat;
        level_target_next  = req_sat;
        last_touch_ms_next = item.now_ms;
      end
      bfs_pkg::FN_SET_SMOOTH: begin
        level_target_next = req_sat;
        fade_step_next    = item.speed;
      end
      bfs_pkg::FN_ON: begin
        level_now_next     = cfg.default_brightness;
        level_target_next  = cfg.default_brightness;
        last_touch_ms_next = item.now_ms;
      end
      bfs_pkg::FN_OFF: begin
        level_now_next     = '0;
        level_target_next  = '0;
        last_touch_ms_next = item.now_ms;
      end
      bfs_pkg::FN_TOGGLE: begin
        level_now_next     = (level_now != '0) ? '0 : cfg.default_brightness;
        level_target_next  = (level_now != '0) ? '0 : cfg.default_brightness;
        last_touch_ms_next = item.now_ms;
      end
      bfs_pkg::FN_TOUCH: begin
        was_off            = (level_now == '0);
        level_now_next     = cfg.default_brightness;
        level_target_next  = cfg.default_brightness;
        last_touch_ms_next = item.now_ms;
      end
      bfs_pkg::FN_INIT: begin
        level_now_next     = cfg.default_brightness;
        level_target_next  = cfg.default_brightness;
        fade_step_next     = bfs_pkg::RESET_STEP;
        last_touch_ms_next = item.now_ms;
      end
      default: begin
      end
    endcase
  end

  assign result.pwm_level     = level_now_next;
  assign result.is_on         = (level_now_next != '0);
  assign result.was_off       = was_off;
  assign result.indicator_led = indicator_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now      <= '0;
      level_target   <= '0;
      fade_step      <= bfs_pkg::RESET_STEP;
      last_touch_ms  <= '0;
      indicator_flag <= 1'b0;
    end else if (fire) begin
      level_now      <= level_now_next;
      level_target   <= level_target_next;
      fade_step      <= fade_step_next;
      last_touch_ms  <= last_touch_ms_next;
      indicator_flag <= indicator_flag_next;
    end
  end

  `BFS_ASSERT_NXT(a_ind_sticky, clk, rst, indicator_flag, indicator_flag)
  `BFS_ASSERT_IMP(a_ind_by_step, clk, rst, $rose(indicator_flag),
                  $past(fire) && ($past(item.func) == bfs_pkg::FN_STEP))
  `BFS_ASSERT_NXT(a_direct_settles, clk, rst,
                  fire && (item.func != bfs_pkg::FN_STEP) &&
                  (item.func != bfs_pkg::FN_SET_SMOOTH),
                  level_now == level_target)

endmodule

/* rtl/backlight_fade_screensaver_core.sv */
// Flow: an accepted item is held in the input register, then moves to the result register
// once that is free or draining, and can be taken on m_tdata; only back-pressure holds it.
// Throughput: one item per cycle without back-pressure; the state update is a 32-bit
// subtract and compare plus an 8-bit add/clamp between the input and result registers.
// Reset (rst, synchronous, active high) empties both registers, clears the levels,
// sets fade step 1, brightness 255, timeout 0 (screensaver off).
// ---------------------------------------------------------------------------
// backlight_fade_screensaver_core
// Backlight PWM level controller with idle fade-out, stream in and out.
// ---------------------------------------------------------------------------
`include "backlight_fade_screensaver_core_defines.svh"

module backlight_fade_screensaver_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [bfs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // command stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bfs_pkg::IN_TDATA_W-1:0]     s_tdata,   // now_ms, level, speed
  input  logic [bfs_pkg::IN_TUSER_W-1:0]     s_tuser,   // func
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bfs_pkg::OUT_TDATA_W-1:0]    m_tdata    // pwm_level, is_on, was_off,
                                                        // indicator_led, zero pad
);

  bfs_pkg::cfg_t    cfg;
  bfs_pkg::item_t   in_item;
  bfs_pkg::result_t result;
  logic             in_valid;
  logic             out_valid;
  logic [bfs_pkg::OUT_TDATA_W-1:0] out_data;
  logic             move;

  // retire the held item whenever the result register is free or draining
  assign move     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || move;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  bfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bfs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func   <= bfs_pkg::func_t'(s_tuser[2:0]);
      in_item.now_ms <= s_tdata[31:0];
      in_item.level  <= s_tdata[47:32];
      in_item.speed  <= s_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= {{(bfs_pkg::OUT_TDATA_W-$bits(bfs_pkg::result_t)){1'b0}}, result};
    end
  end

  `BFS_ASSERT_NXT(a_move_fills_out, clk, rst, move, out_valid)
  `BFS_ASSERT_IMP(a_no_overwrite, clk, rst, out_valid && !m_tready, !move)

endmodule
